// ----- rtl/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

   localparam int FRAME_W            = 12;
   localparam int CFG_W              = 13;
   localparam int COUNT_W            = 13;
   localparam int MAX_FRAMES_DEFAULT = 4096;
   localparam int WORD_BITS_DEFAULT  = 32;
   localparam int SCAN_WORDS         = 16;

   localparam logic [CFG_W-1:0] TOTAL_FRAMES_RESET = 13'h1000;

   typedef enum logic [1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2,
      CMD_TEST    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_HELD = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_MODIFY = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type              command;
      logic [FRAME_W-1:0]   frame_number;
      logic                 for_kernel;
      logic                 wants_write;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [FRAME_W-1:0]   result_frame;
      logic                 present;
      logic                 writable;
      logic                 user_mode;
      logic                 bit_was_set;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/fba_bitmap_ram.sv -----
// ----------------------------------------------------------------------------
// fba_bitmap_ram
// Bitmap word store, one write and one registered read port. A row that has
// never been written reads as all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_bitmap_ram #(
   parameter int WORD_COUNT = 128,
   parameter int WORD_BITS  = 32,
   parameter int ADDR_W     = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [WORD_BITS-1:0]  rd_data,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WORD_BITS-1:0]  wr_data
);

   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] row_valid_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ----- rtl/fba_full_scan.sv -----
// ----------------------------------------------------------------------------
// fba_full_scan
// One flag per bitmap word, set when the word is full. Looks for the lowest
// word that is not full within one chunk of flags per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_full_scan #(
   parameter int WORD_COUNT = 128,
   parameter int ADDR_W     = 7,
   parameter int SCAN_W     = 16,
   parameter int NCHUNK     = 8,
   parameter int CHUNK_W    = 3
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                upd_en,
   input  wire logic [ADDR_W-1:0]   upd_addr,
   input  wire logic                upd_full,
   input  wire logic [CHUNK_W-1:0]  chunk,
   output logic                     found,
   output logic      [ADDR_W-1:0]   word
);

   localparam int PAD    = NCHUNK * SCAN_W;
   localparam int SIDX_W = (SCAN_W > 1) ? $clog2(SCAN_W) : 1;

   logic [WORD_COUNT-1:0] full_ff;
   logic [PAD-1:0]        full_pad;
   logic [SCAN_W-1:0]     chunk_bits;
   logic [SIDX_W-1:0]     idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= '0;
      end else if (upd_en) begin
         full_ff[upd_addr] <= upd_full;
      end
   end

   always_comb begin
      full_pad                   = '1;
      full_pad[WORD_COUNT-1:0]   = full_ff;
      chunk_bits                 = full_pad[int'(chunk) * SCAN_W +: SCAN_W];
      found                      = 1'b0;
      idx                        = '0;
      for (int i = SCAN_W - 1; i >= 0; i--) begin
         if (!chunk_bits[i]) begin
            found = 1'b1;
            idx   = SIDX_W'(i);
         end
      end
      word = ADDR_W'(int'(chunk) * SCAN_W + int'(idx));
   end

endmodule

`default_nettype wire

// ----- rtl/fba_ctrl.sv -----
// ----------------------------------------------------------------------------
// fba_ctrl
// Command sequencer: word lookup or free-word search, read-modify-write of
// the bitmap word, used-frame count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ctrl #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32,
   parameter int ADDR_W     = 7,
   parameter int NCHUNK     = 8,
   parameter int CHUNK_W    = 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire fba_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output fba_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_wr_en,
   input  wire logic [fba_pkg::CFG_W-1:0]    csr_wr_data,
   output logic                              mem_rd_en,
   output logic      [ADDR_W-1:0]            mem_rd_addr,
   input  wire logic [WORD_BITS-1:0]         mem_rd_data,
   output logic                              mem_wr_en,
   output logic      [ADDR_W-1:0]            mem_wr_addr,
   output logic      [WORD_BITS-1:0]         mem_wr_data,
   output logic      [CHUNK_W-1:0]           scan_chunk,
   input  wire logic                         scan_found,
   input  wire logic [ADDR_W-1:0]            scan_word,
   output logic      [fba_pkg::COUNT_W-1:0]  used_count
);

   localparam int BIT_W = $clog2(WORD_BITS);
   localparam int IDX_W = ADDR_W + BIT_W;
   localparam int CMP_W = ((IDX_W > fba_pkg::CFG_W) ? IDX_W : fba_pkg::CFG_W) + 1;
   localparam logic [CMP_W-1:0]   MAX_CMP    = CMP_W'(MAX_FRAMES);
   localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(NCHUNK - 1);

   fba_pkg::state_type            state_ff, state_in;
   fba_pkg::req_type              req_ff;
   fba_pkg::rsp_type              rsp_data_ff, rsp_next;
   logic                          rsp_valid_ff;
   logic                          emit;
   logic [CHUNK_W-1:0]            chunk_ff, chunk_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic                          search_ff, search_in;
   logic [fba_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [fba_pkg::CFG_W-1:0]     total_ff;

   logic [CMP_W-1:0]              limit;
   logic [CMP_W-1:0]              in_frame;
   logic [CMP_W-1:0]              cur_frame;
   logic [CMP_W-1:0]              word_start;
   logic [CMP_W-1:0]              found_frame;
   logic                          out_free;
   logic                          in_range;
   logic                          was;
   logic [BIT_W-1:0]              bit_sel;
   logic [BIT_W-1:0]              sbit;
   logic                          sfound;
   logic [WORD_BITS-1:0]          mask;

   always_comb begin
      limit = CMP_W'(total_ff);
      if (limit > MAX_CMP) begin
         limit = MAX_CMP;
      end
   end

   assign in_frame    = CMP_W'(req_data.frame_number);
   assign cur_frame   = CMP_W'(req_ff.frame_number);
   assign word_start  = CMP_W'(scan_word) << BIT_W;
   assign in_range    = cur_frame < MAX_CMP;
   assign bit_sel     = cur_frame[BIT_W-1:0];
   assign was         = in_range && mem_rd_data[bit_sel];
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign found_frame = CMP_W'({addr_ff, sbit});

   // lowest clear bit of the word under search
   always_comb begin
      sfound = 1'b0;
      sbit   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!mem_rd_data[i]) begin
            sfound = 1'b1;
            sbit   = BIT_W'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      chunk_in    = chunk_ff;
      addr_in     = addr_ff;
      search_in   = search_ff;
      count_in    = count_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = in_frame[BIT_W +: ADDR_W];
      mem_wr_en   = 1'b0;
      mem_wr_data = mem_rd_data;
      emit        = 1'b0;
      rsp_next    = '0;
      mask        = '0;
      case (state_ff)
         fba_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == fba_pkg::CMD_ALLOC &&
                   req_data.frame_number == '0) begin
                  search_in = 1'b1;
                  chunk_in  = '0;
                  state_in  = fba_pkg::ST_SCAN;
               end else begin
                  search_in = 1'b0;
                  mem_rd_en = 1'b1;
                  addr_in   = in_frame[BIT_W +: ADDR_W];
                  state_in  = fba_pkg::ST_MODIFY;
               end
            end
         end
         fba_pkg::ST_SCAN: begin
            if (scan_found && word_start < limit) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_word;
               addr_in     = scan_word;
               state_in    = fba_pkg::ST_MODIFY;
            end else if (scan_found || chunk_ff == LAST_CHUNK) begin
               if (out_free) begin
                  emit            = 1'b1;
                  rsp_next.status = fba_pkg::STATUS_FULL;
                  state_in        = fba_pkg::ST_IDLE;
               end
            end else begin
               chunk_in = chunk_ff + CHUNK_W'(1);
            end
         end
         fba_pkg::ST_MODIFY: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = fba_pkg::ST_IDLE;
               if (search_ff) begin
                  if (sfound && found_frame < limit) begin
                     mask                  = WORD_BITS'(1) << sbit;
                     mem_wr_en             = 1'b1;
                     mem_wr_data           = mem_rd_data | mask;
                     count_in              = count_ff + fba_pkg::COUNT_W'(1);
                     rsp_next.status       = fba_pkg::STATUS_OK;
                     rsp_next.result_frame = found_frame[fba_pkg::FRAME_W-1:0];
                     rsp_next.present      = 1'b1;
                     rsp_next.writable     = req_ff.wants_write;
                     rsp_next.user_mode    = !req_ff.for_kernel;
                  end else begin
                     rsp_next.status = fba_pkg::STATUS_FULL;
                  end
               end else begin
                  mask                 = WORD_BITS'(1) << bit_sel;
                  rsp_next.bit_was_set = was;
                  case (req_ff.command)
                     fba_pkg::CMD_ALLOC: begin
                        rsp_next.status       = fba_pkg::STATUS_HELD;
                        rsp_next.result_frame = req_ff.frame_number;
                     end
                     fba_pkg::CMD_FREE: begin
                        if (req_ff.frame_number != '0 && was) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_data = mem_rd_data & ~mask;
                           count_in    = count_ff - fba_pkg::COUNT_W'(1);
                        end
                     end
                     fba_pkg::CMD_RESERVE: begin
                        if (in_range && !was) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_data = mem_rd_data | mask;
                           count_in    = count_ff + fba_pkg::COUNT_W'(1);
                        end
                        rsp_next.result_frame = req_ff.frame_number;
                     end
                     default: begin
                        rsp_next.result_frame = req_ff.frame_number;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = fba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fba_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chunk_ff     <= '0;
         search_ff    <= 1'b0;
         count_ff     <= '0;
         total_ff     <= fba_pkg::TOTAL_FRAMES_RESET;
      end else begin
         state_ff  <= state_in;
         chunk_ff  <= chunk_in;
         search_ff <= search_in;
         count_ff  <= count_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (state_ff == fba_pkg::ST_IDLE && req_valid) begin
         req_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign req_stall   = (state_ff != fba_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign mem_wr_addr = addr_ff;
   assign scan_chunk  = chunk_ff;
   assign used_count  = count_ff;

endmodule

`default_nettype wire

// ----- rtl/frame_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// First-fit physical frame allocator over a one-bit-per-frame bitmap.
//
//   Port group   Dir   Handshake             Carries
//   req_*        in    req_valid/req_stall   command item (fba_pkg::req_type)
//   rsp_*        out   rsp_valid/rsp_stall   result item (fba_pkg::rsp_type)
//   csr_*        in    csr_wr_en             total_frames, 13 bits
//
// Free, reserve, test and allocate of a page that holds a frame: word read,
// then modify and write back.
// Searching allocate: scan of the full-word flags, 16 words per cycle, then
// the word read and the modify and write back.
// One item at a time; req_stall is high from acceptance until the result is
// loaded into the output register. Reset clears the bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_top #(
   parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire fba_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output fba_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [fba_pkg::CFG_W-1:0]  csr_wr_data
);

   localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int SCAN_W     = (WORD_COUNT < fba_pkg::SCAN_WORDS) ?
                               WORD_COUNT : fba_pkg::SCAN_WORDS;
   localparam int NCHUNK     = (WORD_COUNT + SCAN_W - 1) / SCAN_W;
   localparam int CHUNK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   logic                          mem_rd_en;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic [WORD_BITS-1:0]          mem_rd_data;
   logic                          mem_wr_en;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic [WORD_BITS-1:0]          mem_wr_data;
   logic [CHUNK_W-1:0]            scan_chunk;
   logic                          scan_found;
   logic [ADDR_W-1:0]             scan_word;
   logic [fba_pkg::COUNT_W-1:0]   used_count;

   fba_bitmap_ram #(
      .WORD_COUNT (WORD_COUNT),
      .WORD_BITS  (WORD_BITS),
      .ADDR_W     (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   fba_full_scan #(
      .WORD_COUNT (WORD_COUNT),
      .ADDR_W     (ADDR_W),
      .SCAN_W     (SCAN_W),
      .NCHUNK     (NCHUNK),
      .CHUNK_W    (CHUNK_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .upd_en   (mem_wr_en),
      .upd_addr (mem_wr_addr),
      .upd_full (&mem_wr_data),
      .chunk    (scan_chunk),
      .found    (scan_found),
      .word     (scan_word)
   );

   fba_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS),
      .ADDR_W     (ADDR_W),
      .NCHUNK     (NCHUNK),
      .CHUNK_W    (CHUNK_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .scan_chunk  (scan_chunk),
      .scan_found  (scan_found),
      .scan_word   (scan_word),
      .used_count  (used_count)
   );

   // read and write-back of a bitmap word never share a cycle
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && mem_wr_en))
      else $error("bitmap read and write in the same cycle");

   // the used count moves only with a bitmap write
   a_count_follows_write: assert property (@(posedge clock) disable iff (reset)
      !mem_wr_en |=> $stable(used_count))
      else $error("used count changed without a bitmap write");

   // writes happen only while an item is in progress
   a_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> req_stall)
      else $error("bitmap write while idle");

   // a write is always followed by a result item
   a_write_gives_result: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> rsp_valid)
      else $error("bitmap write without a result item");

endmodule

`default_nettype wire
